### rtl/ecdt_pkg.sv
package ecdt_pkg;

	// Input opcodes as they arrive on the slave side
	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_ADD    = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	// Result kinds as they leave on the master side
	typedef enum logic [1:0] {
		KIND_ADD_REPLY = 2'd0,
		KIND_FIRED     = 2'd1,
		KIND_UPD_DONE  = 2'd2,
		KIND_CLR_DONE  = 2'd3
	} kind_t;

	localparam int unsigned LOW_BITS   = 32;
	localparam int unsigned TIME_BITS  = 64;
	localparam int unsigned QSPACE_BITS = 5;
	localparam int unsigned DELAY_BITS = 20;
	localparam int unsigned TAGIN_BITS = 8;
	localparam int unsigned SLOTOUT_BITS = 4;
	localparam int unsigned SCALE_BITS = 12;
	localparam int unsigned PERIOD_BITS = 32;
	localparam int unsigned PROD_BITS  = DELAY_BITS + SCALE_BITS;
	localparam int unsigned IN_DATA_BITS  = 72;
	localparam int unsigned OUT_DATA_BITS = 80;
	localparam int unsigned CFG_IDX_BITS  = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_TICKS   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_UNIT = 2'd1;

	// One classified request handed from front to back
	typedef struct packed {
		opcode_t                 op;
		logic [LOW_BITS-1:0]     counter_low;
		logic                    overflow_flag;
		logic                    suppress_scan;
		logic [QSPACE_BITS-1:0]  queue_space;
		logic [DELAY_BITS-1:0]   delay_units;
		logic                    has_handler;
		logic [TAGIN_BITS-1:0]   handler_tag;
	} cmd_t;

endpackage

### rtl/extended_counter_deadline_table_top.sv
// Extended counter with a deadline table.
// Slave stream: one request per beat, tuser = opcode (update, add, clear).
// An update folds a timer overflow into the 64-bit upper count and scans the
// deadline slots below the scan limit, firing due ones while the downstream
// queue space lasts. An add takes the lowest free slot; a clear empties all.
// Master stream: one result per beat, tuser = kind; tlast marks the final
// result of a request (an update gives its fired entries, then update done).
// Config channel: cfg_index 0 = period_ticks, 1 = ticks_per_unit; write only
// while idle. cfg_ready is always high.
// Requests enter a two-entry queue, then the sequencer works out the time
// (overflow add in S_TIME, then now = upper + low in S_NOW) before the work.
// The slot scan steps one slot per cycle through the deadline memory port,
// unless a due slot waits on a stalled result register.
// A stalled master holds the result register; the sequencer waits on it while
// the front queue keeps taking requests until it fills.
// Reset clears all slots, the upper count and the scan limit, and loads the
// register defaults; the block is ready in the first cycle after reset.
module extended_counter_deadline_table_top
	import ecdt_pkg::*;
#(
	parameter int unsigned SLOTS    = 16,
	parameter int unsigned TAG_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// counter_low, overflow_flag, suppress_scan, queue_space, delay_units,
	// has_handler, handler_tag, zero pad
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// opcode
	input  logic [1:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// accepted, slot_index, fired_tag, time_now, zero pad
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// kind
	output logic [1:0]               m_tuser,
	// last
	output logic                     m_tlast,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [PERIOD_BITS-1:0]   cfg_data
);

	logic [PERIOD_BITS-1:0] period_q;
	logic [SCALE_BITS-1:0]  scale_q;
	logic                   cmd_valid;
	logic                   cmd_ready;
	cmd_t                   cmd;

	assign cfg_ready = 1'b1;

	// hold register values; writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_BITS'(65536);
			scale_q  <= SCALE_BITS'(1000);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PERIOD_TICKS:   period_q <= cfg_data;
				CFG_TICKS_PER_UNIT: scale_q  <= cfg_data[SCALE_BITS-1:0];
				default:            period_q <= period_q;
			endcase
		end
	end

	// front: accept, classify, queue
	ecdt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// back: time base, slot table, result register
	ecdt_back #(
		.SLOTS    (SLOTS),
		.TAG_BITS (TAG_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.period_ticks   (period_q),
		.ticks_per_unit (scale_q),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast)
	);

endmodule

### rtl/ecdt_front.sv
module ecdt_front
	import ecdt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_DATA_BITS-1:0] s_tdata,
	input  logic [1:0]              s_tuser,
	output logic                    cmd_valid,
	input  logic                    cmd_ready,
	output cmd_t                    cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       in_cmd;
	logic       push;
	logic       pop;

	always_comb begin
		in_cmd.op            = opcode_t'(s_tuser);
		in_cmd.counter_low   = s_tdata[31:0];
		in_cmd.overflow_flag = s_tdata[32];
		in_cmd.suppress_scan = s_tdata[33];
		in_cmd.queue_space   = s_tdata[38:34];
		in_cmd.delay_units   = s_tdata[58:39];
		in_cmd.has_handler   = s_tdata[59];
		in_cmd.handler_tag   = s_tdata[67:60];
	end

	assign s_tready  = (count_q != 2'd2);
	// drop the unused opcode here: it has no effect and no result
	assign push      = s_tvalid && s_tready && (in_cmd.op != OP_NONE);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_cmd;
	end

endmodule

### rtl/ecdt_back.sv
module ecdt_back
	import ecdt_pkg::*;
#(
	parameter int unsigned SLOTS    = 16,
	parameter int unsigned TAG_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  cmd_t                     cmd,
	input  logic [PERIOD_BITS-1:0]   period_ticks,
	input  logic [SCALE_BITS-1:0]    ticks_per_unit,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic [1:0]               m_tuser,
	output logic                     m_tlast
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned LW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TIME,
		S_NOW,
		S_SCAN,
		S_ADD,
		S_CLR
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [TIME_BITS-1:0]    upper_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [PROD_BITS-1:0]    prod_q;
	logic [SLOTS-1:0]        valid_q;
	logic [LW-1:0]           limit_q;
	logic [LW-1:0]           idx_q;
	logic [QSPACE_BITS-1:0]  qs_q;

	logic                    out_valid_q;
	kind_t                   kind_q;
	logic                    acc_q;
	logic [SLOTOUT_BITS-1:0] slot_q;
	logic [TAGIN_BITS-1:0]   tag_q;
	logic [TIME_BITS-1:0]    time_q;
	logic                    last_q;

	logic [TIME_BITS-1:0]    dl_mem [SLOTS];
	logic [TAG_BITS-1:0]     tag_mem [SLOTS];
	logic [TIME_BITS-1:0]    dl_rd;
	logic [TAG_BITS-1:0]     tag_rd;

	logic                    oreg_free;
	logic                    emit;
	logic                    scan_end;
	logic                    due;
	logic                    adv;
	logic [LW-1:0]           idx_next;
	logic [AW-1:0]           rd_addr;
	logic                    free_found;
	logic [AW-1:0]           free_idx;
	logic                    add_ok;
	logic [TIME_BITS-1:0]    when;
	logic                    mem_we;

	assign oreg_free = !out_valid_q || m_tready;
	assign cmd_ready = (state_q == S_IDLE);

	// scan step on the slot whose deadline and tag were read last cycle
	assign scan_end = cmd_q.suppress_scan || (idx_q >= limit_q);
	assign due      = valid_q[idx_q[AW-1:0]] && (now_q >= dl_rd) && (qs_q != '0);
	assign adv      = (state_q == S_SCAN) && !scan_end && (!due || oreg_free);
	assign idx_next = idx_q + LW'(1);
	assign rd_addr  = (state_q == S_SCAN) ? (adv ? idx_next[AW-1:0] : idx_q[AW-1:0]) : '0;

	// load the result register this cycle
	assign emit = oreg_free && (((state_q == S_SCAN) && (scan_end || due)) ||
		(state_q == S_ADD) || (state_q == S_CLR));

	// lowest empty slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(unsigned'(i));
			end
		end
	end

	assign add_ok = (cmd_q.delay_units != '0) && cmd_q.has_handler && free_found;
	assign when   = now_q + TIME_BITS'(prod_q);
	assign mem_we = (state_q == S_ADD) && oreg_free && add_ok;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dl_mem[free_idx]  <= when;
			tag_mem[free_idx] <= TAG_BITS'(cmd_q.handler_tag);
		end
		dl_rd  <= dl_mem[rd_addr];
		tag_rd <= tag_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			upper_q     <= '0;
			now_q       <= '0;
			prod_q      <= '0;
			valid_q     <= '0;
			limit_q     <= '0;
			idx_q       <= '0;
			qs_q        <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_ADD_REPLY;
			acc_q       <= 1'b0;
			slot_q      <= '0;
			tag_q       <= '0;
			time_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !m_tready);
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_TIME;
					end
				end
				S_TIME: begin
					if (cmd_q.op == OP_UPDATE && cmd_q.overflow_flag)
						upper_q <= upper_q + TIME_BITS'(period_ticks);
					state_q <= S_NOW;
				end
				S_NOW: begin
					now_q  <= upper_q + TIME_BITS'(cmd_q.counter_low);
					prod_q <= PROD_BITS'(cmd_q.delay_units) * PROD_BITS'(ticks_per_unit);
					idx_q  <= '0;
					qs_q   <= cmd_q.queue_space;
					case (cmd_q.op)
						OP_UPDATE: state_q <= S_SCAN;
						OP_ADD:    state_q <= S_ADD;
						default:   state_q <= S_CLR;
					endcase
				end
				S_SCAN: begin
					if (scan_end) begin
						if (oreg_free) begin
							kind_q      <= KIND_UPD_DONE;
							acc_q       <= 1'b0;
							slot_q      <= '0;
							tag_q       <= '0;
							time_q      <= now_q;
							last_q      <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else if (due) begin
						if (oreg_free) begin
							kind_q      <= KIND_FIRED;
							acc_q       <= 1'b0;
							slot_q      <= SLOTOUT_BITS'(idx_q);
							tag_q       <= TAGIN_BITS'(tag_rd);
							time_q      <= now_q;
							last_q      <= 1'b0;
							valid_q[idx_q[AW-1:0]] <= 1'b0;
							qs_q        <= qs_q - QSPACE_BITS'(1);
							// firing the top slot shrinks the limit and ends the scan
							if (idx_next >= limit_q) limit_q <= limit_q - LW'(1);
							idx_q       <= idx_next;
						end
					end else begin
						idx_q <= idx_next;
					end
				end
				S_ADD: begin
					if (oreg_free) begin
						kind_q      <= KIND_ADD_REPLY;
						acc_q       <= add_ok;
						slot_q      <= add_ok ? SLOTOUT_BITS'(free_idx) : '0;
						tag_q       <= '0;
						time_q      <= now_q;
						last_q      <= 1'b1;
						if (add_ok) begin
							valid_q[free_idx] <= 1'b1;
							if (LW'(free_idx) >= limit_q) limit_q <= LW'(free_idx) + LW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					if (oreg_free) begin
						kind_q      <= KIND_CLR_DONE;
						acc_q       <= 1'b0;
						slot_q      <= '0;
						tag_q       <= '0;
						time_q      <= now_q;
						last_q      <= 1'b1;
						valid_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, time_q, tag_q, slot_q, acc_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule
